[src/xap_header_parser_top_macros.svh]
// Assertion macros for the header parser.
// Used by xap_header_parser_top; no other dependencies.
`ifndef XAP_HEADER_PARSER_TOP_MACROS_SVH
`define XAP_HEADER_PARSER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define XAP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define XAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define XAP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define XAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/xap_pkg.sv]
// Shared types, constants and character tables for the header parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package xap_pkg;
    localparam int MsgBytes = 4096;
    localparam int PosW = 13;

    typedef enum logic [1:0] {
        K_CHAR = 2'd0, K_FEND = 2'd1, K_ACCEPT = 2'd2, K_REJECT = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        R_NONE = 4'd0, R_OPEN = 4'd1, R_NOEQ = 4'd2, R_KEYLONG = 4'd3,
        R_NONL = 4'd4, R_VALLONG = 4'd5, R_FLDLONG = 4'd6, R_HBEAT = 4'd7,
        R_CMD = 4'd8
    } t_reason;

    typedef enum logic [2:0] {
        REG_KEY = 3'd0, REG_VALUE = 3'd1, REG_UID = 3'd2, REG_CLASS = 3'd3,
        REG_SOURCE = 3'd4, REG_TARGET = 3'd5
    } t_reg_idx;

    localparam logic [2:0] NoKey = 3'd7;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  field_id;
        logic [7:0]  char_value;
        logic        is_heartbeat;
        logic [15:0] version;
        logic [15:0] hop;
        logic [15:0] interval;
        logic [6:0]  present_mask;
        logic [12:0] body_offset;
        logic [3:0]  reject_reason;
    } t_out;

    typedef struct packed {
        logic [2:0] addr;
        logic [7:0] data;
    } t_cfg;

    function automatic logic [7:0] lower8(input logic [7:0] c);
        lower8 = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] open_hdr_ch(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = "x"; 4'd1: r = "a"; 4'd2: r = "p"; 4'd3: r = "-";
            4'd4: r = "h"; 4'd5: r = "e"; 4'd6: r = "a"; 4'd7: r = "d";
            4'd8: r = "e"; 4'd9: r = "r"; 4'd10: r = 8'h0A; 4'd11: r = "{";
            4'd12: r = 8'h0A;
            default: r = "x";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] open_hb_ch(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = "x"; 4'd1: r = "a"; 4'd2: r = "p"; 4'd3: r = "-";
            4'd4: r = "h"; 4'd5: r = "b"; 4'd6: r = "e"; 4'd7: r = "a";
            4'd8: r = "t"; 4'd9: r = 8'h0A; 4'd10: r = "{"; 4'd11: r = 8'h0A;
            4'd12: r = "x";
            default: r = "a";
        endcase
        return r;
    endfunction

    // key name characters, key k position p; 0 past the end
    function automatic logic [7:0] key_ch(input logic [2:0] k, input logic [7:0] p);
        logic [63:0] s;
        unique case (k)
            3'd0: s = {"v", 56'd0};
            3'd1: s = {"hop", 40'd0};
            3'd2: s = {"uid", 40'd0};
            3'd3: s = {"class", 24'd0};
            3'd4: s = {"source", 16'd0};
            3'd5: s = {"target", 16'd0};
            3'd6: s = "interval";
            default: s = 64'd0;
        endcase
        key_ch = (p < 8'd8) ? s[8'd63 - {p[2:0], 3'b000} -: 8] : 8'd0;
    endfunction

    function automatic logic [7:0] key_len(input logic [2:0] k);
        logic [7:0] r;
        unique case (k)
            3'd0: r = 8'd1; 3'd1: r = 8'd3; 3'd2: r = 8'd3; 3'd3: r = 8'd5;
            3'd4: r = 8'd6; 3'd5: r = 8'd6; 3'd6: r = 8'd8;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] class_ch(input logic [1:0] j, input logic [7:0] p);
        logic [119:0] s;
        unique case (j)
            2'd0: s = "xap-hbeat.alive";
            2'd1: s = {"xAPBSC.cmd", 40'd0};
            2'd2: s = {"xAPBSC.query", 24'd0};
            default: s = "xap-x10.request";
        endcase
        class_ch = (p < 8'd15) ? s[8'd119 - {p[3:0], 3'b000} -: 8] : 8'd0;
    endfunction

    function automatic logic [7:0] class_len(input logic [1:0] j);
        logic [7:0] r;
        unique case (j)
            2'd0: r = 8'd15; 2'd1: r = 8'd10; 2'd2: r = 8'd12;
            default: r = 8'd15;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[src/xap_if.sv]
// Valid/ready channel interfaces for the header parser.
// Depends on xap_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface xap_in_if import xap_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface xap_out_if import xap_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface xap_cfg_if import xap_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/xap_num.sv]
// atoi-style decimal accumulator step and 16-bit saturation for the parser.
// Depends on xap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xap_num import xap_pkg::*; (
    input  wire logic [7:0]  i_byte,
    input  wire logic [16:0] i_acc,
    input  wire logic [2:0]  i_stage,
    output logic [16:0]      o_acc,
    output logic [2:0]       o_stage,
    output logic [15:0]      o_value
);
    logic        digit;
    logic        ws;
    logic [1:0]  st;
    logic [20:0] prod;

    always_comb begin
        digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        ws = (i_byte == 8'h20) || (i_byte == 8'h09) || (i_byte == 8'h0B) ||
             (i_byte == 8'h0C) || (i_byte == 8'h0D);
        o_acc = i_acc;
        o_stage = i_stage;
        st = i_stage[1:0];
        prod = {i_acc, 3'b000} + {2'b00, i_acc, 1'b0} + {17'd0, i_byte[3:0] - 4'd0};
        if (st == 2'd0) begin
            if (ws) begin
                st = 2'd3;
            end else if (i_byte == 8'h2D) begin
                o_stage = 3'b101;
                st = 2'd3;
            end else if (i_byte == 8'h2B) begin
                o_stage = 3'b001;
                st = 2'd3;
            end else begin
                st = 2'd1;
                o_stage = {i_stage[2], 2'b01};
            end
        end
        if (st == 2'd1) begin
            if (digit) begin
                o_acc = (prod > 21'd32768) ? 17'd32768 : prod[16:0];
            end else begin
                o_stage = {i_stage[2], 2'b10};
            end
        end
        // saturated value of the incoming accumulator state
        if (i_stage[2]) begin
            o_value = 16'(17'd0 - ((i_acc > 17'd32768) ? 17'd32768 : i_acc));
        end else begin
            o_value = (i_acc > 17'd32767) ? 16'd32767 : i_acc[15:0];
        end
    end
endmodule
`default_nettype wire

[src/xap_header_parser_top.sv]
// Header parser for xAP-style text messages: valid/ready byte stream in,
// tagged results out. Depends on xap_pkg, xap_if, xap_num and the macros header.
//
// Usage:
//  - in channel: one message byte per request with first/last marks.
//  - cfg channel: six 8-bit length limits, written while idle.
//  - out channel: at most one result per byte (value char, field end,
//    accept with body offset, or reject with reason).
//  The result of a byte is written to the output register as the byte is
//  accepted. Throughput: one byte per cycle unless the receiver stalls, set by
//  the single combinational parse step between parser state and output register.
//  The input is taken whenever the output register is empty or being
//  drained in that cycle, so a stalled receiver stops the input after one
//  held result. Reset clears the parser to idle (waiting for a first byte),
//  empties the output register and restores the limit defaults.
//  Bytes without a first mark while idle or finished give no result.
`timescale 1ns / 1ps
`default_nettype none
`include "xap_header_parser_top_macros.svh"
module xap_header_parser_top import xap_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    xap_in_if.sink    in_ch,
    xap_cfg_if.sink   cfg_ch,
    xap_out_if.source out_ch
);
    typedef enum logic [2:0] {
        PH_IDLE, PH_OPEN, PH_LINE, PH_KEY, PH_VALUE, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [PosW-1:0] r_pos, n_pos;
    logic [3:0]  r_oidx, n_oidx;
    logic [7:0]  r_klen, n_klen;
    logic [6:0]  r_kflags, n_kflags;
    logic [7:0]  r_vlen, n_vlen;
    logic [2:0]  r_ckey, n_ckey;
    logic [16:0] r_acc, n_acc;
    logic [2:0]  r_nst, n_nst;
    logic [15:0] r_ver, n_ver, r_hop, n_hop, r_intv, n_intv;
    logic [6:0]  r_seen, n_seen;
    logic [3:0]  r_cflags, n_cflags;
    logic [2:0]  r_ccode, n_ccode;
    logic        r_hb, n_hb;
    logic [7:0]  r_lim [6];
    logic        r_ovalid;
    t_out        r_odata, n_odata;
    logic        n_emit;

    logic        take;
    logic [16:0] num_acc_o;
    logic [2:0]  num_st_o;
    logic [15:0] num_val;
    logic [7:0]  b;

    assign in_ch.ready  = !r_ovalid || out_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;
    assign take = in_ch.valid && in_ch.ready;

    xap_num u_num (
        .i_byte(b), .i_acc(r_acc), .i_stage(r_nst),
        .o_acc(num_acc_o), .o_stage(num_st_o), .o_value(num_val)
    );

    // one parse step per byte
    always_comb begin
        logic [7:0] lb, want, lim;
        logic       first;
        logic [2:0] k;
        t_kind      kd;
        logic [1:0] fid;
        logic [7:0] ch;
        logic [12:0] off;
        t_reason    rsn;
        logic [3:0] olim;
        logic       stop;

        n_phase = r_phase; n_pos = r_pos; n_oidx = r_oidx; n_klen = r_klen;
        n_kflags = r_kflags; n_vlen = r_vlen; n_ckey = r_ckey; n_acc = r_acc;
        n_nst = r_nst; n_ver = r_ver; n_hop = r_hop; n_intv = r_intv;
        n_seen = r_seen; n_cflags = r_cflags; n_ccode = r_ccode; n_hb = r_hb;
        n_emit = 1'b0; kd = K_CHAR; fid = 2'd0; ch = 8'd0; off = 13'd0;
        rsn = R_NONE; stop = 1'b0; want = 8'd0; lim = 8'd0; olim = 4'd0;
        k = r_ckey;
        first = in_ch.data.first_byte;
        b = in_ch.data.data_byte;
        if (first) begin
            n_phase = PH_OPEN; n_pos = '0; n_oidx = '0; n_klen = '0;
            n_kflags = 7'h7F; n_vlen = '0; n_ckey = NoKey; n_acc = '0; n_nst = '0;
            n_ver = '0; n_hop = '0; n_intv = '0; n_seen = '0; n_cflags = 4'hF;
            n_ccode = '0; n_hb = 1'b0;
        end
        if (r_pos == 13'(MsgBytes) && !first) b = 8'd0;
        lb = lower8(b);
        k = n_ckey;
        if (n_phase == PH_OPEN) begin
            olim = n_hb ? 4'd12 : 4'd13;
            want = n_hb ? open_hb_ch(n_oidx) : open_hdr_ch(n_oidx);
            if (n_pos == '0 && b == 8'h0A && n_oidx == 4'd0) begin
                stop = 1'b1;
            end else if (lb != lower8(want)) begin
                if (n_oidx == 4'd5 && !n_hb && lb == "b") begin
                    n_hb = 1'b1; olim = 4'd12;
                end else begin
                    n_emit = 1'b1; kd = K_REJECT; rsn = R_OPEN; n_phase = PH_DONE;
                    stop = 1'b1;
                end
            end
            if (!stop) begin
                n_oidx = n_oidx + 4'd1;
                if (n_oidx >= olim) n_phase = PH_LINE;
            end
            stop = 1'b1;
        end
        if (!stop && n_phase == PH_LINE) begin
            if (b == 8'h7D) begin
                stop = 1'b1;
                n_emit = 1'b1;
                n_phase = PH_DONE;
                if (n_hb && (n_ccode != 3'd1 || n_seen != 7'h5F)) begin
                    kd = K_REJECT; rsn = R_HBEAT;
                end else if (!n_hb && n_ccode >= 3'd2 && n_ccode <= 3'd4 &&
                             n_seen != 7'h3F) begin
                    kd = K_REJECT; rsn = R_CMD;
                end else begin
                    kd = K_ACCEPT; off = n_pos + 13'd2;
                end
            end else begin
                n_phase = PH_KEY; n_klen = '0; n_kflags = 7'h7F;
            end
        end
        if (!stop && n_phase == PH_KEY) begin
            stop = 1'b1;
            if (b == 8'd0) begin
                n_emit = 1'b1; kd = K_REJECT; rsn = R_NOEQ; n_phase = PH_DONE;
            end else if (b == 8'h3D) begin
                if (n_klen >= r_lim[REG_KEY]) begin
                    n_emit = 1'b1; kd = K_REJECT; rsn = R_KEYLONG; n_phase = PH_DONE;
                end else begin
                    n_ckey = NoKey;
                    for (int i = 0; i < 7; i++)
                        if (n_kflags[i] && key_len(3'(i)) == n_klen) n_ckey = 3'(i);
                    n_phase = PH_VALUE; n_vlen = '0; n_acc = '0; n_nst = '0;
                    n_cflags = 4'hF;
                end
            end else begin
                for (int i = 0; i < 7; i++)
                    if (n_kflags[i] && (n_klen >= key_len(3'(i)) ||
                        lb != key_ch(3'(i), n_klen)))
                        n_kflags[i] = 1'b0;
                if (n_klen != 8'd255) n_klen = n_klen + 8'd1;
            end
        end
        if (!stop && n_phase == PH_VALUE) begin
            stop = 1'b1;
            if (b == 8'd0) begin
                n_emit = 1'b1; kd = K_REJECT; rsn = R_NONL; n_phase = PH_DONE;
            end else if (b == 8'h0A) begin
                unique case (k)
                    3'd2: lim = r_lim[REG_UID];
                    3'd3: lim = r_lim[REG_CLASS];
                    3'd4: lim = r_lim[REG_SOURCE];
                    3'd5: lim = r_lim[REG_TARGET];
                    default: lim = 8'd0;
                endcase
                if (n_vlen >= r_lim[REG_VALUE]) begin
                    n_emit = 1'b1; kd = K_REJECT; rsn = R_VALLONG; n_phase = PH_DONE;
                end else begin
                    n_phase = PH_LINE;
                    if (k >= 3'd2 && k <= 3'd5 && n_vlen >= lim) begin
                        n_emit = 1'b1; kd = K_REJECT; rsn = R_FLDLONG; n_phase = PH_DONE;
                    end else if (k != NoKey) begin
                        n_seen[k] = 1'b1;
                        if (k == 3'd0) n_ver = num_val;
                        else if (k == 3'd1) n_hop = num_val;
                        else if (k == 3'd6) n_intv = num_val;
                        else begin
                            if (k == 3'd3) begin
                                n_ccode = '0;
                                for (int j = 0; j < 4; j++)
                                    if (n_cflags[j] && class_len(2'(j)) == n_vlen)
                                        n_ccode = 3'(j + 1);
                            end
                            n_emit = 1'b1; kd = K_FEND; fid = 2'(k - 3'd2);
                        end
                    end
                end
            end else begin
                if (k == 3'd3)
                    for (int j = 0; j < 4; j++)
                        if (n_cflags[j] && (n_vlen >= class_len(2'(j)) ||
                            lb != lower8(class_ch(2'(j), n_vlen))))
                            n_cflags[j] = 1'b0;
                if (n_vlen != 8'd255) n_vlen = n_vlen + 8'd1;
                if (k == 3'd0 || k == 3'd1 || k == 3'd6) begin
                    n_acc = num_acc_o; n_nst = num_st_o;
                end else if (k >= 3'd2 && k <= 3'd5) begin
                    n_emit = 1'b1; kd = K_CHAR; fid = 2'(k - 3'd2); ch = b;
                end
            end
        end
        // position advances for any processed byte, saturating at MsgBytes
        if (r_phase != PH_IDLE && r_phase != PH_DONE || first) begin
            if (n_pos != 13'(MsgBytes)) n_pos = n_pos + 13'd1;
        end else begin
            n_pos = r_pos;
        end
        if ((first || (r_phase != PH_IDLE && r_phase != PH_DONE)) &&
            in_ch.data.last_byte && n_phase != PH_DONE) begin
            n_emit = 1'b1; kd = K_REJECT; fid = 2'd0; ch = 8'd0; off = 13'd0;
            if (n_phase == PH_OPEN) rsn = R_OPEN;
            else if (n_phase == PH_VALUE) rsn = R_NONL;
            else rsn = R_NOEQ;
            n_phase = PH_DONE;
        end
        if (kd == K_REJECT) begin
            fid = 2'd0; ch = 8'd0; off = 13'd0;
        end
        if (!first && (r_phase == PH_IDLE || r_phase == PH_DONE)) begin
            n_emit = 1'b0;
        end
        n_odata = '{kind: kd, field_id: fid, char_value: ch, is_heartbeat: n_hb,
                    version: n_ver, hop: n_hop, interval: n_intv,
                    present_mask: n_seen, body_offset: off, reject_reason: rsn};
    end

    // parser state, limits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_pos <= '0; r_oidx <= '0; r_klen <= '0;
            r_kflags <= 7'h7F; r_vlen <= '0; r_ckey <= NoKey; r_acc <= '0;
            r_nst <= '0; r_ver <= '0; r_hop <= '0; r_intv <= '0; r_seen <= '0;
            r_cflags <= 4'hF; r_ccode <= '0; r_hb <= 1'b0; r_ovalid <= 1'b0;
            r_lim[REG_KEY] <= 8'd32; r_lim[REG_VALUE] <= 8'd128;
            r_lim[REG_UID] <= 8'd32; r_lim[REG_CLASS] <= 8'd64;
            r_lim[REG_SOURCE] <= 8'd128; r_lim[REG_TARGET] <= 8'd128;
        end else begin
            if (cfg_ch.valid && cfg_ch.data.addr <= REG_TARGET)
                r_lim[cfg_ch.data.addr] <= cfg_ch.data.data;
            if (out_ch.ready) r_ovalid <= 1'b0;
            if (take) begin
                r_phase <= n_phase; r_pos <= n_pos; r_oidx <= n_oidx;
                r_klen <= n_klen; r_kflags <= n_kflags; r_vlen <= n_vlen;
                r_ckey <= n_ckey; r_acc <= n_acc; r_nst <= n_nst; r_ver <= n_ver;
                r_hop <= n_hop; r_intv <= n_intv; r_seen <= n_seen;
                r_cflags <= n_cflags; r_ccode <= n_ccode; r_hb <= n_hb;
                if (n_emit) begin
                    r_ovalid <= 1'b1;
                    r_odata <= n_odata;
                end
            end
        end
    end

    `XAP_ASSERT_NEXT(a_done_idle_quiet, i_clk, i_rst_n,
        take && !in_ch.data.first_byte && (r_phase == PH_IDLE || r_phase == PH_DONE)
        && !r_ovalid, !out_ch.valid)
    `XAP_ASSERT_IMPL(a_reject_reason, i_clk, i_rst_n,
        out_ch.valid && out_ch.data.kind == K_REJECT, out_ch.data.reject_reason != R_NONE)
    `XAP_ASSERT_IMPL(a_accept_no_reason, i_clk, i_rst_n,
        out_ch.valid && out_ch.data.kind != K_REJECT, out_ch.data.reject_reason == R_NONE)
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for xap_header_parser_top: byte stream in, tagged results out.
// Depends on xap_pkg, xap_if and the parser RTL; the expected results come from a
// cycle-free predictor of the parser that is kept inside this file.
`timescale 1ns / 1ps
module tb;
    import xap_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int RandomBytes = 1800;
    localparam int KeyV = 0, KeyHop = 1, KeyUid = 2, KeyClass = 3;
    localparam int KeySource = 4, KeyTarget = 5, KeyInterval = 6;
    localparam int KeyOther = 7, KeyEmpty = 8, KeyLong = 9;

    typedef enum int {PS_IDLE, PS_OPEN, PS_LINE, PS_KEY, PS_VALUE, PS_DONE} t_parse_phase;

    typedef struct {
        string   text;
        bit      zero_end;
        bit      last_mark;
        bit      typed;
        t_kind   kind;
        t_reason why;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    xap_in_if  in_ch();
    xap_cfg_if cfg_ch();
    xap_out_if out_ch();

    xap_header_parser_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .cfg_ch  (cfg_ch),
        .out_ch  (out_ch)
    );

    // parser words
    string key_word[7] = '{"v", "hop", "uid", "class", "source", "target", "interval"};
    string class_word[4] = '{"xap-hbeat.alive", "xAPBSC.cmd", "xAPBSC.query",
                             "xap-x10.request"};
    string hdr_open = "xap-header\n{\n";
    string hb_open = "xap-hbeat\n{\n";

    // predictor state
    t_parse_phase ps;
    int unsigned  pos;
    int unsigned  open_idx;
    int unsigned  key_cnt;
    int unsigned  val_cnt;
    logic [6:0]   key_live;
    int unsigned  cur_key;
    int unsigned  num_acc;
    bit           num_neg;
    int unsigned  num_stage;
    logic [15:0]  ver_val, hop_val, intv_val;
    logic [6:0]   seen;
    logic [3:0]   cls_live;
    int unsigned  cls_code;
    bit           hb_flag;
    logic [7:0]   lim[6];

    t_out         result_q[$];
    logic [7:0]   msg_q[$];
    int           errors;
    int           items;
    int           results;
    int           cycles;
    int           hold_asks;
    int           burst_left;
    int           gap_odds;

    function automatic logic [7:0] lc(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic t_out make_res(t_kind kind, int unsigned fid, logic [7:0] ch,
                                      int unsigned off, t_reason why);
        t_out r;
        r.kind = kind;
        r.field_id = fid[1:0];
        r.char_value = ch;
        r.is_heartbeat = hb_flag;
        r.version = ver_val;
        r.hop = hop_val;
        r.interval = intv_val;
        r.present_mask = seen;
        r.body_offset = off[12:0];
        r.reject_reason = why;
        return r;
    endfunction

    function automatic logic [15:0] num_result();
        int unsigned mag;
        mag = num_acc;
        if (num_neg) begin
            if (mag > 32768) mag = 32768;
            return 16'(-mag);
        end
        if (mag > 32767) mag = 32767;
        return mag[15:0];
    endfunction

    // atoi-style accumulation: whitespace, one sign, then digits
    task automatic num_step(logic [7:0] b);
        int unsigned stage;
        stage = num_stage;
        if (stage == 0) begin
            if (b == " " || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D) return;
            if (b == "-") begin
                num_neg = 1;
                num_stage = 1;
                return;
            end
            if (b == "+") begin
                num_stage = 1;
                return;
            end
            stage = 1;
            num_stage = 1;
        end
        if (stage == 1) begin
            if (b >= "0" && b <= "9") begin
                num_acc = num_acc * 10 + (b - "0");
                if (num_acc > 32768) num_acc = 32768;
            end else begin
                num_stage = 2;
            end
        end
    endtask

    task automatic clear_msg();
        pos = 0;
        open_idx = 0;
        key_cnt = 0;
        key_live = '1;
        val_cnt = 0;
        cur_key = NoKey;
        num_acc = 0;
        num_neg = 0;
        num_stage = 0;
        ver_val = 0;
        hop_val = 0;
        intv_val = 0;
        seen = 0;
        cls_live = '1;
        cls_code = 0;
        hb_flag = 0;
    endtask

    task automatic drop_hdr(t_reason why, output bit has, output t_out r);
        ps = PS_DONE;
        has = 1;
        r = make_res(K_REJECT, 0, 8'd0, 0, why);
    endtask

    task automatic close_hdr(output bit has, output t_out r);
        if (hb_flag) begin
            if (cls_code != 1 || seen != 7'h5F) begin
                drop_hdr(R_HBEAT, has, r);
                return;
            end
        end else if (cls_code >= 2 && cls_code <= 4 && seen != 7'h3F) begin
            drop_hdr(R_CMD, has, r);
            return;
        end
        ps = PS_DONE;
        has = 1;
        r = make_res(K_ACCEPT, 0, 8'd0, pos + 2, R_NONE);
    endtask

    task automatic close_value(output bit has, output t_out r);
        int unsigned j;
        has = 0;
        if (val_cnt >= lim[REG_VALUE]) begin
            drop_hdr(R_VALLONG, has, r);
            return;
        end
        ps = PS_LINE;
        if (cur_key > 6) return;
        if (cur_key >= 2 && cur_key <= 5 && val_cnt >= lim[cur_key]) begin
            drop_hdr(R_FLDLONG, has, r);
            return;
        end
        seen[cur_key] = 1'b1;
        case (cur_key)
            KeyV: ver_val = num_result();
            KeyHop: hop_val = num_result();
            KeyInterval: intv_val = num_result();
            default: begin
                if (cur_key == KeyClass) begin
                    cls_code = 0;
                    for (j = 0; j < 4; j++)
                        if (cls_live[j] && class_word[j].len() == val_cnt) cls_code = j + 1;
                end
                has = 1;
                r = make_res(K_FEND, cur_key - 2, 8'd0, 0, R_NONE);
            end
        endcase
    endtask

    task automatic parse_byte(logic [7:0] b, output bit has, output t_out r);
        int unsigned lim_open;
        int unsigned k;
        logic [7:0] want;
        has = 0;
        r = '0;
        // opening line, header or heartbeat
        if (ps == PS_OPEN) begin
            lim_open = hb_flag ? 12 : 13;
            if (pos == 0 && b == 8'h0A && open_idx == 0) return;
            want = hb_flag ? hb_open[open_idx % 12] : hdr_open[open_idx % 13];
            if (lc(b) != lc(want)) begin
                if (open_idx == 5 && !hb_flag && lc(b) == "b") begin
                    hb_flag = 1;
                    lim_open = 12;
                end else begin
                    drop_hdr(R_OPEN, has, r);
                    return;
                end
            end
            open_idx++;
            if (open_idx >= lim_open) ps = PS_LINE;
            return;
        end
        if (ps == PS_LINE) begin
            if (b == "}") begin
                close_hdr(has, r);
                return;
            end
            ps = PS_KEY;
            key_cnt = 0;
            key_live = '1;
        end
        // key name up to the equals sign
        if (ps == PS_KEY) begin
            if (b == 8'd0) begin
                drop_hdr(R_NOEQ, has, r);
                return;
            end
            if (b == "=") begin
                if (key_cnt >= lim[REG_KEY]) begin
                    drop_hdr(R_KEYLONG, has, r);
                    return;
                end
                cur_key = NoKey;
                for (k = 0; k < 7; k++)
                    if (key_live[k] && key_word[k].len() == key_cnt) cur_key = k;
                ps = PS_VALUE;
                val_cnt = 0;
                num_acc = 0;
                num_neg = 0;
                num_stage = 0;
                cls_live = '1;
                return;
            end
            for (k = 0; k < 7; k++)
                if (key_live[k] && (key_cnt >= key_word[k].len() ||
                                    lc(b) != lc(key_word[k][key_cnt])))
                    key_live[k] = 1'b0;
            if (key_cnt < 255) key_cnt++;
            return;
        end
        // value text up to the newline
        if (ps == PS_VALUE) begin
            if (b == 8'd0) begin
                drop_hdr(R_NONL, has, r);
                return;
            end
            if (b == 8'h0A) begin
                close_value(has, r);
                return;
            end
            if (cur_key == KeyClass)
                for (k = 0; k < 4; k++)
                    if (cls_live[k] && (val_cnt >= class_word[k].len() ||
                                        lc(b) != lc(class_word[k][val_cnt])))
                        cls_live[k] = 1'b0;
            if (val_cnt < 255) val_cnt++;
            if (cur_key == KeyV || cur_key == KeyHop || cur_key == KeyInterval) begin
                num_step(b);
            end else if (cur_key >= 2 && cur_key <= 5) begin
                has = 1;
                r = make_res(K_CHAR, cur_key - 2, b, 0, R_NONE);
            end
        end
    endtask

    // one accepted byte: expected result, if any
    task automatic hdr_step(logic [7:0] b_in, bit f, bit l, output bit has, output t_out r);
        logic [7:0] b;
        has = 0;
        r = '0;
        if (f) begin
            clear_msg();
            ps = PS_OPEN;
        end
        if (ps == PS_IDLE || ps == PS_DONE) return;
        b = (pos >= MsgBytes) ? 8'd0 : b_in;
        parse_byte(b, has, r);
        if (pos < MsgBytes) pos++;
        if (l && ps != PS_DONE && ps != PS_IDLE) begin
            if (ps == PS_OPEN) drop_hdr(R_OPEN, has, r);
            else if (ps == PS_VALUE) drop_hdr(R_NONL, has, r);
            else drop_hdr(R_NOEQ, has, r);
        end
    endtask

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("tb: mismatch %s got %0h want %0h (result %0d, t=%0t)",
                 what, got, want, results, $time);
        errors++;
    endtask

    // send one byte request, gaps between bursts
    task automatic send_byte(logic [7:0] b, bit f, bit l, output bit has, output t_out r);
        int g;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 99) < gap_odds) begin
                g = $urandom_range(1, 6);
                in_ch.valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data <= '{data_byte: b, first_byte: f, last_byte: l};
        do @(posedge i_clk); while (!in_ch.ready);
        items++;
        hdr_step(b, f, l, has, r);
        if (has) result_q.push_back(r);
    endtask

    task automatic send_msg(bit last_mark, output bit has, output t_out r);
        bit h;
        t_out x;
        has = 0;
        r = '0;
        for (int i = 0; i < msg_q.size(); i++) begin
            send_byte(msg_q[i], i == 0, last_mark && i == msg_q.size() - 1, h, x);
            if (h) begin
                has = 1;
                r = x;
            end
        end
    endtask

    // drain everything, then leave the block to settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limits(logic [7:0] v[6]);
        for (int i = 0; i < 6; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data <= '{addr: 3'(i), data: v[i]};
            do @(posedge i_clk); while (!cfg_ch.ready);
            lim[i] = v[i];
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [7:0] mix_ch(logic [7:0] c, bit mix);
        if (mix && lc(c) >= "a" && lc(c) <= "z" && $urandom_range(0, 1)) return c ^ 8'h20;
        return c;
    endfunction

    task automatic put_s(string s, bit mix);
        for (int i = 0; i < s.len(); i++) msg_q.push_back(mix_ch(s[i], mix));
    endtask

    task automatic put_rand(int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            do b = 8'($urandom_range(1, 255)); while (b == 8'h0A);
            msg_q.push_back(b);
        end
    endtask

    // one key=value line; cls < 0 picks a random class value
    task automatic put_line(int k, int cls, bit mix);
        int n;
        case (k)
            KeyOther: for (int i = $urandom_range(1, 4); i > 0; i--)
                msg_q.push_back(8'($urandom_range(97, 122)));
            KeyEmpty: ;
            KeyLong: for (int i = $urandom_range(25, 40); i > 0; i--) msg_q.push_back("k");
            default: put_s(key_word[k], mix);
        endcase
        msg_q.push_back("=");
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 140) : $urandom_range(0, 12);
        if (k == KeyV || k == KeyHop || k == KeyInterval) begin
            for (int i = $urandom_range(0, 2); i > 0; i--) msg_q.push_back(" ");
            case ($urandom_range(0, 2))
                0: msg_q.push_back("-");
                1: msg_q.push_back("+");
                default: ;
            endcase
            for (int i = $urandom_range(0, 7); i > 0; i--)
                msg_q.push_back(8'($urandom_range(48, 57)));
            if ($urandom_range(0, 4) == 0) put_rand($urandom_range(1, 3));
        end else if (k == KeyClass && (cls >= 0 || $urandom_range(0, 2) != 0)) begin
            put_s(class_word[cls >= 0 ? cls : $urandom_range(0, 3)], mix);
        end else begin
            put_rand(n);
        end
        msg_q.push_back(8'h0A);
    endtask

    // random message: mostly well-formed headers, some noise and damage
    task automatic build_msg();
        int mode, n, t;
        int keys[$];
        bit mix;
        msg_q.delete();
        mode = $urandom_range(0, 9);
        mix = $urandom_range(0, 1);
        if (mode == 9) begin
            put_rand($urandom_range(1, 20));
            return;
        end
        if ($urandom_range(0, 3) == 0) msg_q.push_back(8'h0A);
        put_s(mode <= 3 ? hb_open : hdr_open, mix);
        if (mode <= 3) keys = '{KeyV, KeyHop, KeyUid, KeyClass, KeySource, KeyInterval};
        else if (mode <= 6) keys = '{KeyV, KeyHop, KeyUid, KeyClass, KeySource, KeyTarget};
        else for (int i = $urandom_range(0, 6); i > 0; i--) keys.push_back($urandom_range(0, 9));
        if ($urandom_range(0, 4) == 0 && keys.size() > 0) keys.delete($urandom_range(0, keys.size() - 1));
        if ($urandom_range(0, 4) == 0) keys.push_back($urandom_range(0, 9));
        for (int i = keys.size() - 1; i > 0; i--) begin
            n = $urandom_range(0, i);
            t = keys[i];
            keys[i] = keys[n];
            keys[n] = t;
        end
        foreach (keys[i])
            put_line(keys[i], (mode <= 3) ? 0 : (mode <= 6 ? $urandom_range(1, 3) : -1), mix);
        msg_q.push_back("}");
        msg_q.push_back(8'h0A);
        put_rand($urandom_range(0, 4));
        // damage: a wrong byte, a zero byte or a cut
        case ($urandom_range(0, 14))
            0: msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
            1: msg_q[$urandom_range(1, msg_q.size() - 1)] = 8'd0;
            2: while (msg_q.size() > 1 && $urandom_range(0, 3) != 0) void'(msg_q.pop_back());
            default: ;
        endcase
    endtask

    t_dir_row dir_rows[10] = '{
        '{"x", 0, 1, 1, K_REJECT, R_OPEN},
        '{"xap-hea", 1, 0, 1, K_REJECT, R_OPEN},
        '{"\nXAP-HBEAT\n{\n}\n", 0, 1, 1, K_REJECT, R_HBEAT},
        '{"xap-header\n{\n}", 0, 0, 1, K_ACCEPT, R_NONE},
        '{"xap-header\n{\nclass=xAPBSC.cmd\n}", 0, 0, 1, K_REJECT, R_CMD},
        '{"xap-header\n{\nv=-99999\nhop=+40000\ninterval= 12x\nuid=\n}", 0, 0, 0,
          K_ACCEPT, R_NONE},
        '{"xap-header\n{\nabc", 0, 1, 1, K_REJECT, R_NOEQ},
        '{"xap-header\n{\nab", 1, 0, 1, K_REJECT, R_NOEQ},
        '{"xap-header\n{\nuid=ab", 0, 1, 1, K_REJECT, R_NONL},
        '{"xAp-HeAdEr\n{\n=5\nSOURCE=a\377\nq=\n}", 0, 1, 0, K_ACCEPT, R_NONE}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: done, errors");
            $finish;
        end
    end

    // receiver: a randomly chosen stall pattern that changes periodically, plus long hold-offs on request
    int rx_mode, rx_count, hold_left, hold_seen;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_mode <= 0;
            rx_count <= 0;
            hold_left <= 0;
            hold_seen <= 0;
        end else begin
            rx_count <= rx_count + 1;
            if (rx_count % 150 == 149) rx_mode <= $urandom_range(0, 3);
            if (hold_seen != hold_asks) begin
                hold_seen <= hold_asks;
                hold_left <= 400;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            results++;
            if (result_q.size() == 0) begin
                $display("tb: unexpected result kind %0d (t=%0t)", got.kind, $time);
                errors++;
            end else begin
                want = result_q.pop_front();
                if (got.kind !== want.kind) report("kind", got.kind, want.kind);
                if (got.field_id !== want.field_id) report("field_id", got.field_id, want.field_id);
                if (got.char_value !== want.char_value)
                    report("char_value", got.char_value, want.char_value);
                if (got.is_heartbeat !== want.is_heartbeat)
                    report("is_heartbeat", got.is_heartbeat, want.is_heartbeat);
                if (got.version !== want.version) report("version", got.version, want.version);
                if (got.hop !== want.hop) report("hop", got.hop, want.hop);
                if (got.interval !== want.interval) report("interval", got.interval, want.interval);
                if (got.present_mask !== want.present_mask)
                    report("present_mask", got.present_mask, want.present_mask);
                if (got.body_offset !== want.body_offset)
                    report("body_offset", got.body_offset, want.body_offset);
                if (got.reject_reason !== want.reject_reason)
                    report("reject_reason", got.reject_reason, want.reject_reason);
            end
        end
    end

    // stimulus
    initial begin
        logic [7:0] v[6];
        bit has;
        t_out r;
        int setting, held, noise;
        errors = 0;
        items = 0;
        results = 0;
        cycles = 0;
        hold_asks = 0;
        burst_left = 0;
        gap_odds = 50;
        held = 0;
        setting = 0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
        ps = PS_IDLE;
        clear_msg();
        lim = '{8'd32, 8'd128, 8'd32, 8'd64, 8'd128, 8'd128};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset limits; a stray byte first is ignored
        send_byte("x", 0, 0, has, r);
        foreach (dir_rows[i]) begin
            msg_q.delete();
            for (int c = 0; c < dir_rows[i].text.len(); c++) msg_q.push_back(dir_rows[i].text[c]);
            if (dir_rows[i].zero_end) msg_q.push_back(8'd0);
            send_msg(dir_rows[i].last_mark, has, r);
            if (dir_rows[i].typed && (!has || r.kind != dir_rows[i].kind ||
                                      r.reject_reason != dir_rows[i].why))
                report("directed row", 16'(i), {r.kind, 10'd0, r.reject_reason});
        end
        wait_idle();

        // random part, a new limit setting every few hundred bytes
        while (items < RandomBytes) begin
            if (items >= 400 * (setting + 1)) begin
                wait_idle();
                setting++;
                for (int i = 0; i < 6; i++) begin
                    case (setting)
                        1: v[i] = 8'd255;
                        2: v[i] = 8'd1;
                        default: v[i] = ($urandom_range(0, 3) == 0) ?
                                        8'($urandom_range(1, 16)) : 8'($urandom_range(1, 255));
                    endcase
                end
                write_limits(v);
                gap_odds = (setting % 2) ? 0 : 60;
            end
            if (!held && items > 900) begin
                held = 1;
                hold_asks++;
            end
            build_msg();
            send_msg($urandom_range(0, 1), has, r);
            if ($urandom_range(0, 4) == 0) begin
                noise = $urandom_range(1, 3);
                for (int i = 0; i < noise; i++)
                    send_byte(8'($urandom_range(0, 255)), 0, $urandom_range(0, 1), has, r);
            end
        end
        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("tb: %0d bytes sent, %0d results checked over %0d limit settings",
                 items, results, setting + 1);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: %0d mismatches", errors);
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

[xap_header_parser_top.f]
+incdir+src
src/xap_pkg.sv
src/xap_if.sv
src/xap_num.sv
src/xap_header_parser_top.sv
tb/sv/tb.sv
